@@ sv/pnjs_pkg.sv @@
// Package with shared types and constants of the nine-point Jacobi sweep.
`timescale 1ns / 1ps
package pnjs_pkg;

    localparam int COEF_WIDTH = 32;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int OUT_POS_WIDTH = 10;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_GRID_COLS     = 3'd0,
        CFG_GRID_ROWS     = 3'd1,
        CFG_COEF_HORZ     = 3'd2,
        CFG_COEF_VERT     = 3'd3,
        CFG_COEF_DIAG     = 3'd4,
        CFG_COEF_SRC_CTR  = 3'd5,
        CFG_COEF_SRC_CROSS = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] horz;
        logic signed [COEF_WIDTH-1:0] vert;
        logic signed [COEF_WIDTH-1:0] diag;
        logic signed [COEF_WIDTH-1:0] src_ctr;
        logic signed [COEF_WIDTH-1:0] src_cross;
    } t_coefs;

    typedef struct packed {
        logic push;
        logic full;
    } t_q_ctrl;

endpackage

@@ sv/pnjs_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module pnjs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/pnjs_front.sv @@
// Front end: raster position tracking, line buffers, 3x3 windows and interior detection.
`timescale 1ns / 1ps
module pnjs_front #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024,
    parameter int SAMPLE_WIDTH = 32,
    parameter int ITEM_W = 14 * 32 + 21
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [10:0]             i_grid_cols,
    input  logic [10:0]             i_grid_rows,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SAMPLE_WIDTH-1:0] i_potential,
    input  logic [SAMPLE_WIDTH-1:0] i_source,
    input  logic                    i_q_full,
    output pnjs_pkg::t_q_ctrl       o_q_ctrl,
    output logic [ITEM_W-1:0]       o_item
);
    import pnjs_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CMPW = 17;

    logic          en, accept;
    logic [CMPW-1:0] cols, rows;
    logic [CW-1:0] r_col, n_col, c0;
    logic [RW-1:0] r_row, n_row, r0;
    logic [RW:0]   row_inc;
    logic [CMPW-1:0] c0_next, r0_next;

    logic          r_s1_valid;
    logic [SW-1:0] r_s1_p, r_s1_s;
    logic [CW-1:0] r_s1_c;
    logic [RW-1:0] r_s1_r;
    logic          r_s1_int, r_s1_last;

    logic [SW-1:0] r_pw [9];
    logic [SW-1:0] r_sw [9];
    logic [SW-1:0] n_pw [9];
    logic [SW-1:0] n_sw [9];
    logic [2*SW-1:0] line0_rd, line1_rd;

    assign en = !i_q_full;
    assign o_ready = en;
    assign accept = i_valid && en;

    always_comb begin
        if (CMPW'(i_grid_cols) < CMPW'(5)) begin
            cols = CMPW'(5);
        end else if (CMPW'(i_grid_cols) > CMPW'(MAX_COLS)) begin
            cols = CMPW'(MAX_COLS);
        end else begin
            cols = CMPW'(i_grid_cols);
        end
        if (CMPW'(i_grid_rows) < CMPW'(3)) begin
            rows = CMPW'(3);
        end else if (CMPW'(i_grid_rows) > CMPW'(MAX_ROWS)) begin
            rows = CMPW'(MAX_ROWS);
        end else begin
            rows = CMPW'(i_grid_rows);
        end
    end

    // Position fixup covers sizes that were shrunk in the middle of a frame.
    always_comb begin
        if (CMPW'(r_col) >= cols) begin
            c0 = '0;
            row_inc = (RW+1)'(r_row) + (RW+1)'(1);
        end else begin
            c0 = r_col;
            row_inc = (RW+1)'(r_row);
        end
        r0 = (CMPW'(row_inc) >= rows) ? '0 : RW'(row_inc);
        c0_next = CMPW'(c0) + CMPW'(1);
        r0_next = CMPW'(r0) + CMPW'(1);
        if (c0_next >= cols) begin
            n_col = '0;
            n_row = (r0_next >= rows) ? '0 : RW'(r0_next);
        end else begin
            n_col = CW'(c0_next);
            n_row = r0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_p <= i_potential;
            r_s1_s <= i_source;
            r_s1_c <= c0;
            r_s1_r <= r0;
            r_s1_int <= (r0 >= RW'(2)) && (c0 >= CW'(2));
            r_s1_last <= (CMPW'(r0) == rows - CMPW'(1)) && (CMPW'(c0) == cols - CMPW'(1));
        end
    end

    // Line 0 holds the previous row, line 1 the row before it.
    pnjs_ram #(.WIDTH(2 * SW), .DEPTH(1 << CW)) u_line0 (
        .i_clk  (i_clk),
        .i_we   (en && r_s1_valid),
        .i_waddr(r_s1_c),
        .i_wdata({r_s1_s, r_s1_p}),
        .i_re   (accept),
        .i_raddr(c0),
        .o_rdata(line0_rd)
    );

    pnjs_ram #(.WIDTH(2 * SW), .DEPTH(1 << CW)) u_line1 (
        .i_clk  (i_clk),
        .i_we   (en && r_s1_valid),
        .i_waddr(r_s1_c),
        .i_wdata(line0_rd),
        .i_re   (accept),
        .i_raddr(c0),
        .o_rdata(line1_rd)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_pw[k*3+0] = r_pw[k*3+1];
            n_pw[k*3+1] = r_pw[k*3+2];
            n_sw[k*3+0] = r_sw[k*3+1];
            n_sw[k*3+1] = r_sw[k*3+2];
        end
        n_pw[2] = line1_rd[SW-1:0];
        n_pw[5] = line0_rd[SW-1:0];
        n_pw[8] = r_s1_p;
        n_sw[2] = line1_rd[2*SW-1:SW];
        n_sw[5] = line0_rd[2*SW-1:SW];
        n_sw[8] = r_s1_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_pw[k] <= '0;
                r_sw[k] <= '0;
            end
        end else if (en && r_s1_valid) begin
            r_pw <= n_pw;
            r_sw <= n_sw;
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            o_item[k*SW +: SW] = n_pw[k];
        end
        o_item[9*SW +: SW]  = n_sw[1];
        o_item[10*SW +: SW] = n_sw[3];
        o_item[11*SW +: SW] = n_sw[4];
        o_item[12*SW +: SW] = n_sw[5];
        o_item[13*SW +: SW] = n_sw[7];
        o_item[14*SW +: CW] = r_s1_c;
        o_item[14*SW+CW +: RW] = r_s1_r;
        o_item[14*SW+CW+RW] = r_s1_last;
    end

    assign o_q_ctrl.push = en && r_s1_valid && r_s1_int;
    assign o_q_ctrl.full = i_q_full;
endmodule

@@ sv/pnjs_queue.sv @@
// Short register queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
module pnjs_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pnjs_pkg::t_q_ctrl     i_ctrl,
    input  logic [WIDTH-1:0]      i_data,
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic                  o_full,
    output logic [WIDTH-1:0]      o_data
);
    import pnjs_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [NW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_count <= '0;
        end else begin
            if (i_ctrl.push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_ctrl.push && !i_pop) begin
                r_count <= r_count + NW'(1);
            end else if (!i_ctrl.push && i_pop) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full = (r_count == NW'(DEPTH));
    assign o_data = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.push |-> !o_full)
        else $error("queue push while full");
    a_full_agrees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.full == o_full)
        else $error("front end sees a different full state");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(DEPTH))
        else $error("queue count out of range");
endmodule

@@ sv/pnjs_back.sv @@
// Back end: weighted stencil sums, rounding, saturation and running maximum change.
`timescale 1ns / 1ps
module pnjs_back #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024,
    parameter int SAMPLE_WIDTH = 32,
    parameter int ITEM_W = 14 * 32 + 21,
    parameter int OUT_W = 88
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pnjs_pkg::t_coefs      i_coefs,
    input  logic                  i_q_valid,
    input  logic [ITEM_W-1:0]     i_item,
    output logic                  o_pop,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [OUT_W-1:0]      o_tdata,
    output logic                  o_tlast
);
    import pnjs_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int SUW = SW + 2;
    localparam int PRW = SUW + COEF_WIDTH;
    localparam int TW  = PRW - 30;
    localparam int AW  = TW + 3;
    localparam int PAD = OUT_W - (3 * SW - 1 + 2 * OUT_POS_WIDTH);

    localparam logic signed [AW-1:0] SAT_HI = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = {{(AW-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic [SW:0] MAG_MAX = {2'b00, {(SW-1){1'b1}}};
    localparam logic signed [PRW-1:0] HALF = PRW'(1) <<< 29;

    logic en;
    logic signed [SW-1:0] w [9];
    logic signed [SW-1:0] q1, q3, q4, q5, q7;

    logic                 r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic signed [SUW-1:0] r_sum [5];
    logic signed [PRW-1:0] r_prod [5];
    logic signed [SW-1:0]  r_c1, r_c2, r_c3, r_c4;
    logic [CW-1:0] r_col1, r_col2, r_col3, r_col4;
    logic [RW-1:0] r_row1, r_row2, r_row3, r_row4;
    logic r_l1, r_l2, r_l3, r_l4;
    logic signed [AW-1:0] r_acc;
    logic signed [SW-1:0] r_sat;
    logic signed [SW:0]   r_delta;
    logic signed [COEF_WIDTH-1:0] coef [5];
    logic signed [TW-1:0] term [5];
    logic signed [AW-1:0] acc_sum, acc_sat;
    logic [SW:0]   mag_wide;
    logic [SW-2:0] mag, new_max;
    logic [SW-2:0] r_max;
    logic [SW-1:0] r_o_pot;
    logic [SW-2:0] r_o_max;
    logic [OUT_POS_WIDTH-1:0] r_o_row, r_o_col;
    logic r_o_last;

    assign en = !r_out_valid || i_tready;
    assign o_pop = en && i_q_valid;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w[k] = i_item[k*SW +: SW];
        end
        q1 = i_item[9*SW +: SW];
        q3 = i_item[10*SW +: SW];
        q4 = i_item[11*SW +: SW];
        q5 = i_item[12*SW +: SW];
        q7 = i_item[13*SW +: SW];
        coef[0] = i_coefs.horz;
        coef[1] = i_coefs.vert;
        coef[2] = i_coefs.diag;
        coef[3] = i_coefs.src_ctr;
        coef[4] = i_coefs.src_cross;
    end

    // Round each scaled product to Q8.24, ties toward plus infinity.
    always_comb begin
        acc_sum = '0;
        for (int k = 0; k < 5; k++) begin
            term[k] = TW'((r_prod[k] + HALF) >>> 30);
            acc_sum = acc_sum + AW'(term[k]);
        end
        if (r_acc > SAT_HI) begin
            acc_sat = SAT_HI;
        end else if (r_acc < SAT_LO) begin
            acc_sat = SAT_LO;
        end else begin
            acc_sat = r_acc;
        end
        mag_wide = r_delta[SW] ? (SW+1)'(-r_delta) : (SW+1)'(r_delta);
        mag = (mag_wide > MAG_MAX) ? {(SW-1){1'b1}} : mag_wide[SW-2:0];
        new_max = (mag > r_max) ? mag : r_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_out_valid <= 1'b0;
            r_max <= '0;
        end else if (en) begin
            r_v1 <= i_q_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_out_valid <= r_v4;
            if (r_v4) begin
                r_max <= r_l4 ? '0 : new_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum[0] <= SUW'(w[3]) + SUW'(w[5]);
            r_sum[1] <= SUW'(w[1]) + SUW'(w[7]);
            r_sum[2] <= SUW'(w[0]) + SUW'(w[2]) + SUW'(w[6]) + SUW'(w[8]);
            r_sum[3] <= SUW'(q4);
            r_sum[4] <= SUW'(q1) + SUW'(q7) + SUW'(q3) + SUW'(q5);
            r_c1 <= w[4];
            r_col1 <= i_item[14*SW +: CW];
            r_row1 <= i_item[14*SW+CW +: RW];
            r_l1 <= i_item[14*SW+CW+RW];

            for (int k = 0; k < 5; k++) begin
                r_prod[k] <= PRW'(r_sum[k]) * PRW'(coef[k]);
            end
            r_c2 <= r_c1;
            r_col2 <= r_col1;
            r_row2 <= r_row1;
            r_l2 <= r_l1;

            r_acc <= acc_sum;
            r_c3 <= r_c2;
            r_col3 <= r_col2;
            r_row3 <= r_row2;
            r_l3 <= r_l2;

            r_sat <= SW'(acc_sat);
            r_delta <= (SW+1)'(SW'(acc_sat)) - (SW+1)'(r_c3);
            r_c4 <= r_c3;
            r_col4 <= r_col3;
            r_row4 <= r_row3;
            r_l4 <= r_l3;

            r_o_pot <= r_sat;
            r_o_max <= new_max;
            r_o_row <= OUT_POS_WIDTH'(r_row4 - RW'(1));
            r_o_col <= OUT_POS_WIDTH'(r_col4 - CW'(1));
            r_o_last <= r_l4;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tlast = r_o_last;
    assign o_tdata = {{PAD{1'b0}}, r_o_max, r_o_col, r_o_row, r_o_pot};

    a_max_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_v4 && r_l4) |=> (r_max == '0))
        else $error("running maximum not cleared after frame end");
    a_max_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_v4 && !r_l4) |=> (r_max >= $past(r_max)))
        else $error("running maximum decreased within a frame");
    a_out_max_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_v4) |=> (r_o_max >= $past(r_max)))
        else $error("reported maximum below running maximum");
endmodule

@@ sv/poisson_nine_point_jacobi_sweep.sv @@
// A result's path: front-end register, item queue, back-end sum, product, accumulator, saturation and output registers.
// Throughput: one sample per cycle unless the queue is full; the line buffers are read and written once per sample.
// Boundary samples produce no result; results stall only on output backpressure.
// Reset (i_rst_n low, synchronous) clears position, windows, queue and running maximum.
// Line buffer contents are not cleared; unwritten entries never reach a result.
`timescale 1ns / 1ps
module poisson_nine_point_jacobi_sweep #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // potential_in, source_in
    input  logic [((2*SAMPLE_WIDTH)+7)/8*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // potential_out, out_row, out_col, max_change
    output logic [((3*SAMPLE_WIDTH-1+2*pnjs_pkg::OUT_POS_WIDTH)+7)/8*8-1:0] o_m_tdata,
    output logic o_m_tlast,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [pnjs_pkg::CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [pnjs_pkg::COEF_WIDTH-1:0]    i_cfg_data
);
    import pnjs_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int ITEM_W = 14 * SW + CW + RW + 1;
    localparam int OUT_W = ((3 * SW - 1 + 2 * OUT_POS_WIDTH) + 7) / 8 * 8;
    localparam int Q_DEPTH = 4;

    logic [10:0] r_grid_cols, r_grid_rows;
    t_coefs r_coefs;
    t_q_ctrl q_ctrl;
    logic q_full, q_valid, q_pop;
    logic [ITEM_W-1:0] front_item, q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= 11'd1024;
            r_grid_rows <= 11'd1024;
            r_coefs <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GRID_COLS:      r_grid_cols <= i_cfg_data[10:0];
                CFG_GRID_ROWS:      r_grid_rows <= i_cfg_data[10:0];
                CFG_COEF_HORZ:      r_coefs.horz <= i_cfg_data;
                CFG_COEF_VERT:      r_coefs.vert <= i_cfg_data;
                CFG_COEF_DIAG:      r_coefs.diag <= i_cfg_data;
                CFG_COEF_SRC_CTR:   r_coefs.src_ctr <= i_cfg_data;
                CFG_COEF_SRC_CROSS: r_coefs.src_cross <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pnjs_front #(
        .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS),
        .SAMPLE_WIDTH(SW), .ITEM_W(ITEM_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_grid_cols(r_grid_cols),
        .i_grid_rows(r_grid_rows),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_potential(i_s_tdata[SW-1:0]),
        .i_source   (i_s_tdata[2*SW-1:SW]),
        .i_q_full   (q_full),
        .o_q_ctrl   (q_ctrl),
        .o_item     (front_item)
    );

    pnjs_queue #(.WIDTH(ITEM_W), .DEPTH(Q_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (q_ctrl),
        .i_data (front_item),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_full (q_full),
        .o_data (q_item)
    );

    pnjs_back #(
        .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS),
        .SAMPLE_WIDTH(SW), .ITEM_W(ITEM_W), .OUT_W(OUT_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coefs  (r_coefs),
        .i_q_valid(q_valid),
        .i_item   (q_item),
        .o_pop    (q_pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );
endmodule
